@@ hw/rtl/qau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// Request and response types, widths and helpers for the quaternion unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int unsigned CompW   = 16;              // Q2.14 component
  localparam int unsigned FracW   = 14;              // fraction bits
  localparam int unsigned ProdW   = 2 * CompW;       // exact 16x16 product
  localparam int unsigned SumW    = ProdW + 2;       // sum of four products
  localparam int unsigned ValW    = SumW - FracW + 1; // shifted value, also holds negation
  localparam int unsigned CoefW   = ProdW + 2;       // rotation matrix coefficient
  localparam int unsigned RotPW   = CoefW + CompW;   // coefficient times component
  localparam int unsigned RotSW   = RotPW + 2;       // sum of three such products
  localparam int unsigned RotValW = RotSW - 2 * FracW; // rotation sum back at Q2.14
  localparam int unsigned SatW    = (RotValW > ValW) ? RotValW : ValW;

  typedef enum logic [1:0] {
    FuncMul  = 2'd0,
    FuncRot  = 2'd1,
    FuncConj = 2'd2,
    FuncLen  = 2'd3
  } qau_func_e;

  typedef struct packed {
    qau_func_e               func;
    logic signed [CompW-1:0] a_w;
    logic signed [CompW-1:0] a_x;
    logic signed [CompW-1:0] a_y;
    logic signed [CompW-1:0] a_z;
    logic signed [CompW-1:0] b_w;
    logic signed [CompW-1:0] b_x;
    logic signed [CompW-1:0] b_y;
    logic signed [CompW-1:0] b_z;
  } qau_req_t;

  typedef struct packed {
    logic signed [CompW-1:0] r_w;
    logic signed [CompW-1:0] r_x;
    logic signed [CompW-1:0] r_y;
    logic signed [CompW-1:0] r_z;
  } qau_rsp_t;

  // Clamp a wide signed value to the 16-bit signed range.
  function automatic logic signed [CompW-1:0] qau_sat(input logic signed [SatW-1:0] v);
    logic signed [SatW-1:0] max_v;
    logic signed [SatW-1:0] min_v;
    max_v = SatW'({1'b0, {(CompW-1){1'b1}}});
    min_v = -max_v - SatW'(1);
    if (v > max_v) begin
      return {1'b0, {(CompW-1){1'b1}}};
    end else if (v < min_v) begin
      return {1'b1, {(CompW-1){1'b0}}};
    end else begin
      return CompW'(v);
    end
  endfunction

endpackage

@@ hw/rtl/quaternion_arith_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arith_unit
// Four-stage fixed-point quaternion pipeline: product, rotation, conjugate,
// squared length.
// ----------------------------------------------------------------------------
// Fully pipelined Q2.14 quaternion unit. One request is accepted per clock
// while in_stall_o is low; its response is registered through stages 1 to 4,
// and out_valid_o rises when stage 4 loads it. There are four register
// stages; the first one loads at the accepting edge:
//   stage 1 - all exact 16x16 products (a*b for multiply, a*a for the rest)
//   stage 2 - sums: product components, squared length, conjugate, and the
//             rotation matrix coefficients (cross terms doubled)
//   stage 3 - rotation coefficients times the vector components
//   stage 4 - rotation sums, arithmetic shift, saturation, result select
// Sums are exact; results are floor-shifted to Q2.14 and saturated to 16 bits.
// Rotate does not normalize a, so the vector is also scaled by |a|^2. r_w is
// zero for rotate, r_x..r_z are zero for length squared. A stall on the
// output freezes only the stages that are full behind it, so bubbles still
// collapse and in_stall_o is high only when every stage holds a request.
module quaternion_arith_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qau_pkg::qau_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qau_pkg::qau_rsp_t out_rsp_o
);
  import qau_pkg::*;

  // ---------------- pipeline control ----------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic s1_v_d, s2_v_d, s3_v_d, s4_v_d;
  logic en1, en2, en3, en4;

  // A stage loads when it is empty or its contents move on.
  assign en4 = !s4_v_q || !out_stall_i;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;

  assign in_stall_o  = !en1;
  assign out_valid_o = s4_v_q;

  assign s1_v_d = en1 ? in_valid_i : s1_v_q;
  assign s2_v_d = en2 ? s1_v_q     : s2_v_q;
  assign s3_v_d = en3 ? s2_v_q     : s3_v_q;
  assign s4_v_d = en4 ? s3_v_q     : s4_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      s3_v_q <= s3_v_d;
      s4_v_q <= s4_v_d;
    end
  end

  // ---------------- stage 1: products ----------------
  // index order 0..3 = w, x, y, z
  logic signed [CompW-1:0] a_op [4];
  logic signed [CompW-1:0] b_op [4];
  logic signed [ProdW-1:0] ab_d [4][4];   // a_i * b_j
  logic signed [ProdW-1:0] aa_d [4][4];   // a_i * a_j, upper triangle used

  assign a_op[0] = in_req_i.a_w;
  assign a_op[1] = in_req_i.a_x;
  assign a_op[2] = in_req_i.a_y;
  assign a_op[3] = in_req_i.a_z;
  assign b_op[0] = in_req_i.b_w;
  assign b_op[1] = in_req_i.b_x;
  assign b_op[2] = in_req_i.b_y;
  assign b_op[3] = in_req_i.b_z;

  // Multiply never needs a*a and the others never need a*b, but both sets
  // are narrow enough that sharing would only add operand muxing.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        ab_d[i][j] = ProdW'(a_op[i] * b_op[j]);
        aa_d[i][j] = (j >= i) ? ProdW'(a_op[i] * a_op[j]) : '0;
      end
    end
  end

  qau_func_e               s1_func_q;
  logic signed [ProdW-1:0] s1_ab_q [4][4];
  logic signed [ProdW-1:0] s1_aa_q [4][4];
  logic signed [CompW-1:0] s1_a_q  [4];
  logic signed [CompW-1:0] s1_b_q  [3];   // vector part for rotation

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_func_q <= in_req_i.func;
      s1_ab_q   <= ab_d;
      s1_aa_q   <= aa_d;
      s1_a_q    <= a_op;
      s1_b_q[0] <= in_req_i.b_x;
      s1_b_q[1] <= in_req_i.b_y;
      s1_b_q[2] <= in_req_i.b_z;
    end
  end

  // ---------------- stage 2: sums and coefficients ----------------
  logic signed [SumW-1:0]  mul_s [4];
  logic signed [SumW-1:0]  len_s;
  logic signed [ProdW:0]   dxy, dxz, dyz, dwx, dwy, dwz;
  logic signed [ProdW-1:0] ww, xx, yy, zz;
  logic signed [ValW-1:0]  val_d [4];
  logic signed [CoefW-1:0] coef_d [3][3];

  assign ww = s1_aa_q[0][0];
  assign xx = s1_aa_q[1][1];
  assign yy = s1_aa_q[2][2];
  assign zz = s1_aa_q[3][3];
  assign dwx = (ProdW+1)'(s1_aa_q[0][1]) <<< 1;
  assign dwy = (ProdW+1)'(s1_aa_q[0][2]) <<< 1;
  assign dwz = (ProdW+1)'(s1_aa_q[0][3]) <<< 1;
  assign dxy = (ProdW+1)'(s1_aa_q[1][2]) <<< 1;
  assign dxz = (ProdW+1)'(s1_aa_q[1][3]) <<< 1;
  assign dyz = (ProdW+1)'(s1_aa_q[2][3]) <<< 1;

  // Hamilton product terms
  assign mul_s[0] = SumW'(s1_ab_q[0][0]) - SumW'(s1_ab_q[1][1])
                  - SumW'(s1_ab_q[2][2]) - SumW'(s1_ab_q[3][3]);
  assign mul_s[1] = SumW'(s1_ab_q[1][0]) + SumW'(s1_ab_q[0][1])
                  + SumW'(s1_ab_q[2][3]) - SumW'(s1_ab_q[3][2]);
  assign mul_s[2] = SumW'(s1_ab_q[0][2]) - SumW'(s1_ab_q[1][3])
                  + SumW'(s1_ab_q[2][0]) + SumW'(s1_ab_q[3][1]);
  assign mul_s[3] = SumW'(s1_ab_q[0][3]) + SumW'(s1_ab_q[1][2])
                  - SumW'(s1_ab_q[2][1]) + SumW'(s1_ab_q[3][0]);
  assign len_s    = SumW'(ww) + SumW'(xx) + SumW'(yy) + SumW'(zz);

  always_comb begin
    coef_d[0][0] = CoefW'(ww) + CoefW'(xx) - CoefW'(yy) - CoefW'(zz);
    coef_d[0][1] = CoefW'(dxy) - CoefW'(dwz);
    coef_d[0][2] = CoefW'(dxz) + CoefW'(dwy);
    coef_d[1][0] = CoefW'(dxy) + CoefW'(dwz);
    coef_d[1][1] = CoefW'(ww) - CoefW'(xx) + CoefW'(yy) - CoefW'(zz);
    coef_d[1][2] = CoefW'(dyz) - CoefW'(dwx);
    coef_d[2][0] = CoefW'(dxz) - CoefW'(dwy);
    coef_d[2][1] = CoefW'(dyz) + CoefW'(dwx);
    coef_d[2][2] = CoefW'(ww) - CoefW'(xx) - CoefW'(yy) + CoefW'(zz);
  end

  // Non-rotate results, already back at Q2.14 but not yet saturated.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      val_d[i] = '0;
    end
    unique case (s1_func_q)
      FuncMul: begin
        for (int i = 0; i < 4; i++) begin
          val_d[i] = ValW'(mul_s[i] >>> FracW);
        end
      end
      FuncConj: begin
        val_d[0] = ValW'(s1_a_q[0]);
        for (int i = 1; i < 4; i++) begin
          val_d[i] = -ValW'(s1_a_q[i]);
        end
      end
      FuncLen: begin
        val_d[0] = ValW'(len_s >>> FracW);
      end
      default: begin
        // rotate: carried values stay zero
      end
    endcase
  end

  qau_func_e               s2_func_q;
  logic signed [ValW-1:0]  s2_val_q  [4];
  logic signed [CoefW-1:0] s2_coef_q [3][3];
  logic signed [CompW-1:0] s2_b_q    [3];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_func_q <= s1_func_q;
      s2_val_q  <= val_d;
      s2_coef_q <= coef_d;
      s2_b_q    <= s1_b_q;
    end
  end

  // ---------------- stage 3: rotation products ----------------
  logic signed [RotPW-1:0] rp_d [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rp_d[i][j] = RotPW'(s2_coef_q[i][j] * s2_b_q[j]);
      end
    end
  end

  qau_func_e               s3_func_q;
  logic signed [ValW-1:0]  s3_val_q [4];
  logic signed [RotPW-1:0] s3_rp_q  [3][3];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_func_q <= s2_func_q;
      s3_val_q  <= s2_val_q;
      s3_rp_q   <= rp_d;
    end
  end

  // ---------------- stage 4: rotation sums, saturate, select ----------------
  logic signed [RotSW-1:0]   rot_s [3];
  logic signed [RotValW-1:0] rot_v [3];
  logic signed [CompW-1:0]   res_d [4];
  qau_rsp_t                  rsp_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rot_s[i] = RotSW'(s3_rp_q[i][0]) + RotSW'(s3_rp_q[i][1]) + RotSW'(s3_rp_q[i][2]);
      rot_v[i] = RotValW'(rot_s[i] >>> (2 * FracW));
    end
    for (int i = 0; i < 4; i++) begin
      res_d[i] = qau_sat(SatW'(s3_val_q[i]));
    end
    if (s3_func_q == FuncRot) begin
      for (int i = 0; i < 3; i++) begin
        res_d[i+1] = qau_sat(SatW'(rot_v[i]));
      end
    end
    rsp_d.r_w = res_d[0];
    rsp_d.r_x = res_d[1];
    rsp_d.r_y = res_d[2];
    rsp_d.r_z = res_d[3];
  end

  qau_rsp_t s4_rsp_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_rsp_q <= rsp_d;
    end
  end

  assign out_rsp_o = s4_rsp_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Q2.14 quaternion unit: a directed table of
// products, rotations, conjugates and squared lengths (extremes, saturation,
// floor rounding), then random requests. Every response is compared field by
// field with a typed row or independent predictor, under random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
  import qau_pkg::*;

  localparam int unsigned NumRandom = 850;
  localparam int unsigned MaxIdle   = 13;
  localparam int unsigned DrainWait = 8;

  typedef struct packed {
    qau_req_t req;
    logic     known;   // response typed into the table
    qau_rsp_t rsp;
  } op_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  qau_req_t in_req = '0;
  logic     in_known = 1'b0;
  qau_rsp_t in_typed = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  qau_rsp_t out_rsp;

  op_row_t  op_list[$];
  qau_rsp_t pending_rsp_q[$];
  int       err_cnt = 0;

  quaternion_arith_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic signed [CompW-1:0] clamp_q214(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[CompW-1:0];
  endfunction

  // Expected response of one request, exact 64-bit arithmetic.
  function automatic qau_rsp_t quat_compute(qau_req_t q);
    longint   aw, ax, ay, az, bw, bx, by, bz;
    longint   ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
    longint   rw, rx, ry, rz;
    qau_rsp_t r;
    aw = $signed(q.a_w);
    ax = $signed(q.a_x);
    ay = $signed(q.a_y);
    az = $signed(q.a_z);
    bw = $signed(q.b_w);
    bx = $signed(q.b_x);
    by = $signed(q.b_y);
    bz = $signed(q.b_z);
    rw = 0;
    rx = 0;
    ry = 0;
    rz = 0;
    case (q.func)
      FuncMul: begin
        rw = (aw * bw - ax * bx - ay * by - az * bz) >>> FracW;
        rx = (ax * bw + aw * bx + ay * bz - az * by) >>> FracW;
        ry = (aw * by - ax * bz + ay * bw + az * bx) >>> FracW;
        rz = (aw * bz + ax * by - ay * bx + az * bw) >>> FracW;
      end
      FuncRot: begin
        ww = aw * aw;
        xx = ax * ax;
        yy = ay * ay;
        zz = az * az;
        // cross terms carry the factor two of the sandwich expansion
        wx = 2 * aw * ax;
        wy = 2 * aw * ay;
        wz = 2 * aw * az;
        xy = 2 * ax * ay;
        xz = 2 * ax * az;
        yz = 2 * ay * az;
        rx = ((ww + xx - yy - zz) * bx + (xy - wz) * by + (xz + wy) * bz) >>> (2 * FracW);
        ry = ((xy + wz) * bx + (ww - xx + yy - zz) * by + (yz - wx) * bz) >>> (2 * FracW);
        rz = ((xz - wy) * bx + (yz + wx) * by + (ww - xx - yy + zz) * bz) >>> (2 * FracW);
      end
      FuncConj: begin
        rw = aw;
        rx = -ax;
        ry = -ay;
        rz = -az;
      end
      FuncLen: begin
        rw = (aw * aw + ax * ax + ay * ay + az * az) >>> FracW;
      end
    endcase
    r.r_w = clamp_q214(rw);
    r.r_x = clamp_q214(rx);
    r.r_y = clamp_q214(ry);
    r.r_z = clamp_q214(rz);
    return r;
  endfunction

  function automatic qau_req_t mk_req(qau_func_e f, int aw, int ax, int ay, int az,
                                      int bw, int bx, int by, int bz);
    qau_req_t q;
    q.func = f;
    q.a_w  = 16'(aw);
    q.a_x  = 16'(ax);
    q.a_y  = 16'(ay);
    q.a_z  = 16'(az);
    q.b_w  = 16'(bw);
    q.b_x  = 16'(bx);
    q.b_y  = 16'(by);
    q.b_z  = 16'(bz);
    return q;
  endfunction

  function automatic qau_rsp_t mk_rsp(int rw, int rx, int ry, int rz);
    qau_rsp_t r;
    r.r_w = 16'(rw);
    r.r_x = 16'(rx);
    r.r_y = 16'(ry);
    r.r_z = 16'(rz);
    return r;
  endfunction

  // Mix of extremes, full-range noise and magnitudes under one half (keeps
  // rotations and products out of saturation most of the time).
  function automatic int rand_comp();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return -32768;
          1: return 32767;
          2: return 0;
          3: return 16384;
          4: return -16384;
          default: return -1;
        endcase
      end
      1, 2, 3, 4: return int'($signed(16'($urandom)));
      default: return int'($urandom_range(0, 16383)) - 8192;
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [CompW-1:0] want,
                                      logic signed [CompW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // Single observer of both handshakes, sampled at the edge.
  always @(posedge clk_i) begin
    qau_rsp_t want;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        pending_rsp_q.push_back(in_known ? in_typed : quat_compute(in_req));
      end
      if (out_valid && !out_stall) begin
        if (pending_rsp_q.size() == 0) begin
          $error("response with no request outstanding");
          err_cnt++;
        end else begin
          want = pending_rsp_q.pop_front();
          check_field("r_w", want.r_w, out_rsp.r_w);
          check_field("r_x", want.r_x, out_rsp.r_x);
          check_field("r_y", want.r_y, out_rsp.r_y);
          check_field("r_z", want.r_z, out_rsp.r_z);
        end
      end
    end
  end

  // Output side: stall a random number of cycles before each response.
  initial begin
    int unsigned hold;
    bit          rush;
    rush = 1'b0;
    forever begin
      if ($urandom_range(0, 29) == 0) rush = ~rush;
      hold = rush ? 0 : $urandom_range(0, MaxIdle);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin
    int unsigned gap;
    int unsigned guard;
    bit          rush;

    // directed table
    op_list.push_back('{mk_req(FuncConj, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0)});
    // negating the most negative value saturates
    op_list.push_back('{mk_req(FuncConj, -32768, -32768, 32767, -32768, 0, 0, 0, 0), 1'b1,
                        mk_rsp(-32768, 32767, -32767, 32767)});
    op_list.push_back('{mk_req(FuncConj, 32767, 0, 1, -1, 0, 0, 0, 0), 1'b1,
                        mk_rsp(32767, 0, -1, 1)});
    op_list.push_back('{mk_req(FuncConj, 5, -5, 0, 0, -32768, 32767, -32768, 32767), 1'b1,
                        mk_rsp(5, 5, 0, 0)});
    op_list.push_back('{mk_req(FuncMul, 16384, 0, 0, 0, 1234, -5678, 32767, -32768), 1'b1,
                        mk_rsp(1234, -5678, 32767, -32768)});
    op_list.push_back('{mk_req(FuncMul, -32768, 0, 0, 0, -32768, 0, 0, 0), 1'b1,
                        mk_rsp(32767, 0, 0, 0)});
    op_list.push_back('{mk_req(FuncMul, -32768, 0, 0, 0, 32767, 0, 0, 0), 1'b1,
                        mk_rsp(-32768, 0, 0, 0)});
    op_list.push_back('{mk_req(FuncMul, 0, 16384, 0, 0, 0, 0, 16384, 0), 1'b1,
                        mk_rsp(0, 0, 0, 16384)});
    // floor rounding of a tiny negative product
    op_list.push_back('{mk_req(FuncMul, 1, 0, 0, 0, -1, 0, 0, 0), 1'b1, mk_rsp(-1, 0, 0, 0)});
    op_list.push_back('{mk_req(FuncMul, 1, 0, 0, 0, 1, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0)});
    op_list.push_back('{mk_req(FuncMul, 32767, 32767, 32767, 32767, 32767, -32768, -32768,
                               -32768), 1'b0, '0});
    op_list.push_back('{mk_req(FuncMul, 11585, -4000, 8000, -12000, 9000, 3000, -7000, 15000),
                        1'b0, '0});
    op_list.push_back('{mk_req(FuncRot, 16384, 0, 0, 0, 777, 1000, -2000, 32767), 1'b1,
                        mk_rsp(0, 1000, -2000, 32767)});
    op_list.push_back('{mk_req(FuncRot, 0, 0, 0, 16384, 0, 100, -200, 300), 1'b1,
                        mk_rsp(0, -100, 200, 300)});
    // unnormalized rotor scales the vector and saturates
    op_list.push_back('{mk_req(FuncRot, -32768, -32768, -32768, -32768, 0, 0, 0, 32767), 1'b1,
                        mk_rsp(0, 32767, 0, 0)});
    op_list.push_back('{mk_req(FuncRot, 0, 0, 0, 0, 32767, -32768, -32768, -32768), 1'b1,
                        mk_rsp(0, 0, 0, 0)});
    op_list.push_back('{mk_req(FuncRot, 16384, 0, 0, 0, -32768, 5, 6, 7), 1'b1,
                        mk_rsp(0, 5, 6, 7)});
    op_list.push_back('{mk_req(FuncRot, 11585, 0, 11585, 0, 0, 16384, 0, 0), 1'b0, '0});
    op_list.push_back('{mk_req(FuncRot, 32767, -32768, 32767, -32768, 0, 32767, -32768, 32767),
                        1'b0, '0});
    op_list.push_back('{mk_req(FuncLen, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0)});
    op_list.push_back('{mk_req(FuncLen, 16384, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        mk_rsp(16384, 0, 0, 0)});
    op_list.push_back('{mk_req(FuncLen, -32768, -32768, -32768, -32768, 1, 2, 3, 4), 1'b1,
                        mk_rsp(32767, 0, 0, 0)});
    op_list.push_back('{mk_req(FuncLen, 32767, 32767, 0, 0, 0, 0, 0, 0), 1'b1,
                        mk_rsp(32767, 0, 0, 0)});
    op_list.push_back('{mk_req(FuncLen, 0, 0, 0, 1, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0)});
    op_list.push_back('{mk_req(FuncLen, 8000, -9000, 3000, -100, 0, 0, 0, 0), 1'b0, '0});

    // random requests, checked against the predictor
    repeat (NumRandom) begin
      op_list.push_back('{mk_req(qau_func_e'($urandom_range(0, 3)), rand_comp(), rand_comp(),
                                 rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                                 rand_comp(), rand_comp()), 1'b0, '0});
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rush = 1'b0;
    foreach (op_list[i]) begin
      if ($urandom_range(0, 39) == 0) rush = ~rush;
      gap = rush ? 0 : $urandom_range(0, MaxIdle);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid <= 1'b1;
      in_req   <= op_list[i].req;
      in_known <= op_list[i].known;
      in_typed <= op_list[i].rsp;
      do @(posedge clk_i); while (in_stall);
    end
    in_valid <= 1'b0;

    guard = 0;
    while (pending_rsp_q.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DrainWait) @(posedge clk_i);
    if (pending_rsp_q.size() != 0) begin
      $error("%0d responses never arrived", pending_rsp_q.size());
      err_cnt++;
    end

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/qau_pkg.sv
hw/rtl/quaternion_arith_unit.sv
tb/sv/testbench.sv
